// ----- src/sdtb_pkg.sv -----
// Shared types and constants for the state delay timer bank.
package sdtb_pkg;

    localparam int NUM_SLOTS_DEFAULT = 16;

    localparam int MODE_W   = 2;
    localparam int TICK_W   = 32;
    localparam int SLOT_W   = 4;
    localparam int DELAY_W  = 24;
    localparam int TPS_W    = 10;
    localparam int WAIT_W   = 16;
    localparam int USED_W   = 5;
    localparam int PROD_W   = DELAY_W + TPS_W;
    localparam int FRAC_W   = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [TPS_W-1:0]  TPS_RESET      = 10'd60;
    localparam logic [WAIT_W-1:0] MAX_WAIT_RESET = 16'd600;

    typedef enum logic [0:0] {
        REG_TICKS_PER_SECOND = 1'b0,
        REG_MAX_WAIT         = 1'b1
    } reg_index_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_ENTRY = 2'd0,
        MODE_ARM   = 2'd1,
        MODE_TEST  = 2'd2,
        MODE_WAIT  = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t               mode;
        logic [TICK_W-1:0]   now_tick;
        logic [SLOT_W-1:0]   slot;
        logic [DELAY_W-1:0]  delay_seconds;
    } cmd_word_t;

    typedef struct packed {
        logic                fired;
        logic [WAIT_W-1:0]   wait_ticks;
    } rsp_word_t;

endpackage

// ----- src/sdtb_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module sdtb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/state_delay_timer_bank.sv -----
// Top level of the state delay timer bank: a bank of one-shot delay timers.
//
// A command word enters on cmd/cmd_valid and is taken when cmd_stall is low.
// One response word leaves on rsp/rsp_valid for every command and is held
// until a cycle in which rsp_stall is low. Registers are written through the
// APB port: ticks_per_second at address 0, max_wait at address 4.
// A command is handled by a small sequencer around one shared 32-bit adder:
//   state entry:  goes from acceptance straight to the response,
//   arm slot:     multiply, then add to the entry tick,
//   test slot:    deadline read, then compare,
//   next wait:    walks the used slots, one slot per cycle through the adder.
// The block takes one command at a time; cmd_stall is high from acceptance
// until the response has moved into the output register, so the next command
// can be taken in the cycle after that. If the receiver stalls, the finished
// response waits in the output register and the block may still take one more
// command, whose result waits in turn. Reset clears all deadlines (per-slot
// valid bits), the entry tick, the used count and restores ticks_per_second
// to 60 and max_wait to 600.
module state_delay_timer_bank #(
    parameter int NUM_SLOTS = sdtb_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  sdtb_pkg::cmd_word_t           cmd,
    input  logic                          cmd_valid,
    output logic                          cmd_stall,
    output sdtb_pkg::rsp_word_t           rsp,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sdtb_pkg::PADDR_W-1:0]  paddr,
    input  logic [sdtb_pkg::PDATA_W-1:0]  pwdata,
    output logic [sdtb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_ARM  = 5'b00010,
        ST_TEST = 5'b00100,
        ST_WALK = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t                              state_reg, state_next;
    logic [sdtb_pkg::TPS_W-1:0]          tps_reg, tps_next;
    logic [sdtb_pkg::WAIT_W-1:0]         max_wait_reg, max_wait_next;
    logic [sdtb_pkg::TICK_W-1:0]         entry_reg, entry_next;
    logic [sdtb_pkg::USED_W-1:0]         used_reg, used_next;
    logic [NUM_SLOTS-1:0]                valid_reg, valid_next;
    logic [sdtb_pkg::USED_W-1:0]         cnt_reg, cnt_next;
    logic [sdtb_pkg::TICK_W-1:0]         now_reg, now_next;
    logic [IDX_W-1:0]                    slot_reg, slot_next;
    logic [sdtb_pkg::PROD_W-1:0]         prod_reg, prod_next;
    sdtb_pkg::rsp_word_t                 res_reg, res_next;
    sdtb_pkg::rsp_word_t                 out_reg, out_next;
    logic                                out_valid_reg, out_valid_next;

    logic                                cmd_take;
    logic                                cfg_write;
    logic                                slot_ok;
    logic [IDX_W-1:0]                    cmd_idx;
    logic [IDX_W-1:0]                    walk_idx;
    logic [IDX_W-1:0]                    rd_addr;
    logic [sdtb_pkg::TICK_W-1:0]         rd_data;
    logic [sdtb_pkg::TICK_W-1:0]         deadline;
    logic                                ram_we;
    logic [sdtb_pkg::TICK_W-1:0]         alu_a, alu_b;
    logic                                alu_sub;
    logic [sdtb_pkg::TICK_W:0]           alu_sum;
    logic [sdtb_pkg::USED_W-1:0]         slot_plus;

    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_take  = cmd_valid && (state_reg == ST_IDLE);
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign rsp       = out_reg;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        unique case (sdtb_pkg::reg_index_t'(paddr[2]))
            sdtb_pkg::REG_TICKS_PER_SECOND: prdata = sdtb_pkg::PDATA_W'(tps_reg);
            sdtb_pkg::REG_MAX_WAIT:         prdata = sdtb_pkg::PDATA_W'(max_wait_reg);
            default:                        prdata = '0;
        endcase
    end

    assign slot_ok   = (32'(cmd.slot) < NUM_SLOTS);
    assign cmd_idx   = IDX_W'(cmd.slot);
    assign walk_idx  = IDX_W'(cnt_reg);
    assign deadline  = (state_reg == ST_WALK) ? (valid_reg[walk_idx] ? rd_data : '0)
                                              : (valid_reg[slot_reg] ? rd_data : '0);
    assign ram_we    = (state_reg == ST_ARM);
    assign slot_plus = sdtb_pkg::USED_W'(slot_reg) + sdtb_pkg::USED_W'(1);

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: rd_addr = (cmd.mode == sdtb_pkg::MODE_WAIT) ? '0 : cmd_idx;
            ST_WALK: rd_addr = IDX_W'(cnt_reg + sdtb_pkg::USED_W'(1));
            default: rd_addr = slot_reg;
        endcase
    end

    // Shared adder: add for arming, subtract for the test and the walk.
    always_comb
    begin
        unique case (state_reg)
            ST_ARM:
            begin
                alu_a   = entry_reg;
                alu_b   = sdtb_pkg::TICK_W'(prod_reg[sdtb_pkg::PROD_W-1:sdtb_pkg::FRAC_W]);
                alu_sub = 1'b0;
            end
            ST_TEST:
            begin
                alu_a   = now_reg;
                alu_b   = deadline;
                alu_sub = 1'b1;
            end
            ST_WALK:
            begin
                alu_a   = deadline;
                alu_b   = now_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
        alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                + (sdtb_pkg::TICK_W + 1)'(alu_sub);
    end

    sdtb_ram #(
        .WIDTH (sdtb_pkg::TICK_W),
        .DEPTH (NUM_SLOTS)
    ) u_deadline_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_reg),
        .wdata (alu_sum[sdtb_pkg::TICK_W-1:0]),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        tps_next       = tps_reg;
        max_wait_next  = max_wait_reg;
        entry_next     = entry_reg;
        used_next      = used_reg;
        valid_next     = valid_reg;
        cnt_next       = cnt_reg;
        now_next       = now_reg;
        slot_next      = slot_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && rsp_stall;

        if (cfg_write)
        begin
            unique case (sdtb_pkg::reg_index_t'(paddr[2]))
                sdtb_pkg::REG_TICKS_PER_SECOND: tps_next = pwdata[sdtb_pkg::TPS_W-1:0];
                sdtb_pkg::REG_MAX_WAIT:         max_wait_next = pwdata[sdtb_pkg::WAIT_W-1:0];
                default:                        tps_next = tps_reg;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_take)
                begin
                    now_next  = cmd.now_tick;
                    slot_next = cmd_idx;
                    prod_next = sdtb_pkg::PROD_W'(cmd.delay_seconds) * sdtb_pkg::PROD_W'(tps_reg);
                    cnt_next  = '0;
                    res_next  = '0;
                    unique case (cmd.mode)
                        sdtb_pkg::MODE_ENTRY:
                        begin
                            entry_next = cmd.now_tick;
                            used_next  = '0;
                            state_next = ST_DONE;
                        end
                        sdtb_pkg::MODE_ARM:
                        begin
                            state_next = slot_ok ? ST_ARM : ST_DONE;
                        end
                        sdtb_pkg::MODE_TEST:
                        begin
                            res_next.fired = !slot_ok;
                            state_next     = slot_ok ? ST_TEST : ST_DONE;
                        end
                        sdtb_pkg::MODE_WAIT:
                        begin
                            res_next.wait_ticks = max_wait_reg;
                            state_next = (used_reg == '0) ? ST_DONE : ST_WALK;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_ARM:
            begin
                valid_next[slot_reg] = 1'b1;
                if (slot_plus > used_reg)
                begin
                    used_next = slot_plus;
                end
                state_next = ST_DONE;
            end
            ST_TEST:
            begin
                if (deadline == '0)
                begin
                    res_next.fired = 1'b1;
                end
                else if (alu_sum[sdtb_pkg::TICK_W])
                begin
                    res_next.fired       = 1'b1;
                    valid_next[slot_reg] = 1'b0;
                end
                state_next = ST_DONE;
            end
            ST_WALK:
            begin
                if (deadline != '0)
                begin
                    if ((alu_sum[sdtb_pkg::TICK_W-1:0] == '0) || alu_sum[sdtb_pkg::TICK_W-1])
                    begin
                        res_next.wait_ticks  = '0;
                        valid_next[walk_idx] = 1'b0;
                    end
                    else if (alu_sum[sdtb_pkg::TICK_W-1:0]
                             < sdtb_pkg::TICK_W'(res_reg.wait_ticks))
                    begin
                        res_next.wait_ticks = alu_sum[sdtb_pkg::WAIT_W-1:0];
                    end
                end
                cnt_next = cnt_reg + sdtb_pkg::USED_W'(1);
                if (cnt_next == used_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !rsp_stall)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tps_reg       <= sdtb_pkg::TPS_RESET;
            max_wait_reg  <= sdtb_pkg::MAX_WAIT_RESET;
            entry_reg     <= '0;
            used_reg      <= '0;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tps_reg       <= tps_next;
            max_wait_reg  <= max_wait_next;
            entry_reg     <= entry_next;
            used_reg      <= used_next;
            valid_reg     <= valid_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg  <= now_next;
        slot_reg <= slot_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

endmodule
